// ----- hw/rtl/bpsm_pkg.sv -----
// bpsm_pkg: shared types and constants of the battery power-state monitor
// power modes, configuration register layout and fixed thresholds
// no dependencies
`default_nettype none

package bpsm_pkg;

   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int CSR_ADDR_W            = 5;
   localparam int CSR_DATA_W            = 32;
   localparam int MV_W                  = 14;

   // register indexes on the csr port (byte address is 4 * index)
   localparam logic [2:0] REG_USB_THRESHOLD    = 3'd0;
   localparam logic [2:0] REG_LOW_THRESHOLD    = 3'd1;
   localparam logic [2:0] REG_STEP_THRESHOLD   = 3'd2;
   localparam logic [2:0] REG_SMOOTHING_WEIGHT = 3'd3;
   localparam logic [2:0] REG_CHANGE_THRESHOLD = 3'd4;

   localparam logic [13:0] USB_THRESHOLD_RESET    = 14'd4500;
   localparam logic [13:0] LOW_THRESHOLD_RESET    = 14'd3300;
   localparam logic [13:0] STEP_THRESHOLD_RESET   = 14'd200;
   localparam logic [8:0]  SMOOTHING_WEIGHT_RESET = 9'd26;
   localparam logic [9:0]  CHANGE_THRESHOLD_RESET = 10'd20;

   localparam logic [8:0]  WEIGHT_FULL   = 9'd256;
   localparam logic [13:0] ADC_OFFSET_MV = 14'd65;
   localparam logic [13:0] VOLTAGE_MAX   = 14'd8255;
   localparam logic [2:0]  SETTLE_COUNT  = 3'd5;
   localparam logic [3:0]  LOW_LIMIT     = 4'd10;
   localparam logic [1:0]  DEBOUNCE_MAX  = 2'd3;

   localparam logic [6:0]  PCT_FULL      = 7'd100;
   localparam logic [6:0]  PCT_CHARGING  = 7'd101;
   localparam logic [6:0]  PCT_USB       = 7'd102;

   typedef enum logic [2:0] {
      MODE_RUN      = 3'd0,
      MODE_USB      = 3'd1,
      MODE_INIT     = 3'd2,
      MODE_LOW      = 3'd3,
      MODE_FULL     = 3'd4,
      MODE_CHARGING = 3'd5
   } mode_type;

   typedef struct packed {
      logic [13:0] usb_threshold_mv;
      logic [13:0] low_threshold_mv;
      logic [13:0] step_threshold_mv;
      logic [8:0]  smoothing_weight;
      logic [9:0]  change_threshold_mv;
   } cfg_type;

   // per-item status handed from the control stage to the output stage
   typedef struct packed {
      logic [13:0] voltage_mv;
      mode_type    mode;
      logic        usb_powered;
      logic        report_changed;
      logic        sleep_request;
      logic        pct_update;
   } info_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bpsm_req_if.sv -----
// bpsm_req_if: input channel of the battery power-state monitor
// valid/ready handshake with one converter reading and the charger pin
// no dependencies
`default_nettype none

interface bpsm_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] adc_millivolts;
   logic        charger_low;

   modport source (output valid, output adc_millivolts, output charger_low, input ready);
   modport sink   (input valid, input adc_millivolts, input charger_low, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpsm_rsp_if.sv -----
// bpsm_rsp_if: result channel of the battery power-state monitor
// valid/ready handshake with voltage, percentage, state and flags
// no dependencies
`default_nettype none

interface bpsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] voltage_mv;
   logic [6:0]  percentage;
   logic [2:0]  power_state;
   logic        usb_powered;
   logic        report_changed;
   logic        sleep_request;

   modport source (output valid, output voltage_mv, output percentage, output power_state,
                   output usb_powered, output report_changed, output sleep_request,
                   input ready);
   modport sink   (input valid, input voltage_mv, input percentage, input power_state,
                   input usb_powered, input report_changed, input sleep_request,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpsm_csr.sv -----
// bpsm_csr: APB-style configuration registers of the power-state monitor
// depends on bpsm_pkg
`default_nettype none

module bpsm_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bpsm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [bpsm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [bpsm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready,
   output bpsm_pkg::cfg_type                         cfg
);

   bpsm_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_index;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.usb_threshold_mv    <= bpsm_pkg::USB_THRESHOLD_RESET;
         cfg_ff.low_threshold_mv    <= bpsm_pkg::LOW_THRESHOLD_RESET;
         cfg_ff.step_threshold_mv   <= bpsm_pkg::STEP_THRESHOLD_RESET;
         cfg_ff.smoothing_weight    <= bpsm_pkg::SMOOTHING_WEIGHT_RESET;
         cfg_ff.change_threshold_mv <= bpsm_pkg::CHANGE_THRESHOLD_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            bpsm_pkg::REG_USB_THRESHOLD:    cfg_ff.usb_threshold_mv    <= csr_pwdata[13:0];
            bpsm_pkg::REG_LOW_THRESHOLD:    cfg_ff.low_threshold_mv    <= csr_pwdata[13:0];
            bpsm_pkg::REG_STEP_THRESHOLD:   cfg_ff.step_threshold_mv   <= csr_pwdata[13:0];
            bpsm_pkg::REG_SMOOTHING_WEIGHT: cfg_ff.smoothing_weight    <= csr_pwdata[8:0];
            bpsm_pkg::REG_CHANGE_THRESHOLD: cfg_ff.change_threshold_mv <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         bpsm_pkg::REG_USB_THRESHOLD:    csr_prdata = {18'd0, cfg_ff.usb_threshold_mv};
         bpsm_pkg::REG_LOW_THRESHOLD:    csr_prdata = {18'd0, cfg_ff.low_threshold_mv};
         bpsm_pkg::REG_STEP_THRESHOLD:   csr_prdata = {18'd0, cfg_ff.step_threshold_mv};
         bpsm_pkg::REG_SMOOTHING_WEIGHT: csr_prdata = {23'd0, cfg_ff.smoothing_weight};
         bpsm_pkg::REG_CHANGE_THRESHOLD: csr_prdata = {22'd0, cfg_ff.change_threshold_mv};
         default:                        csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bpsm_filter.sv -----
// bpsm_filter: input stage, corrects the reading and updates the voltage filter
// depends on bpsm_pkg and bpsm_req_if
`default_nettype none

module bpsm_filter #(
   parameter int FRACTION_BITS = bpsm_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  bpsm_pkg::cfg_type                       cfg,
   bpsm_req_if.sink                                req,
   output logic                                    f_valid,
   input  wire logic                               f_ready,
   output logic [13:0]                             f_raw,
   output logic                                    f_chg,
   output logic [13+FRACTION_BITS:0]               f_filt
);

   localparam int FW = 14 + FRACTION_BITS;

   logic                   f_valid_ff;
   logic                   primed_ff;
   logic [FW-1:0]          filt_ff;
   logic [FW-1:0]          filt_in;
   logic [13:0]            raw_ff;
   logic                   chg_ff;
   logic [13:0]            raw;
   logic [FW-1:0]          raw_fx;
   logic [FW-1:0]          f0;
   logic [FW-1:0]          diff;
   logic [FW-1:0]          step_fx;
   logic [8:0]             weight;
   logic signed [FW:0]     delta;
   logic signed [FW+10:0]  prod;
   logic signed [FW+10:0]  adj;
   logic signed [FW+10:0]  sum;
   logic                   accept;

   assign raw     = {1'b0, req.adc_millivolts, 1'b0} + bpsm_pkg::ADC_OFFSET_MV;
   assign raw_fx  = {raw, {FRACTION_BITS{1'b0}}};
   assign step_fx = {cfg.step_threshold_mv, {FRACTION_BITS{1'b0}}};
   // first item after reset loads the filter with its own reading
   assign f0      = primed_ff ? filt_ff : raw_fx;
   assign diff    = (raw_fx > f0) ? (raw_fx - f0) : (f0 - raw_fx);
   assign weight  = (cfg.smoothing_weight > bpsm_pkg::WEIGHT_FULL) ? bpsm_pkg::WEIGHT_FULL
                                                                   : cfg.smoothing_weight;

   // f + floor(w * (raw - f) / 256), same as the weighted sum of both terms
   assign delta   = $signed({1'b0, raw_fx}) - $signed({1'b0, f0});
   assign prod    = delta * $signed({1'b0, weight});
   assign adj     = prod >>> 8;
   assign sum     = $signed({11'd0, f0}) + adj;
   assign filt_in = (diff > step_fx) ? raw_fx : sum[FW-1:0];

   assign accept    = req.valid && req.ready;
   assign req.ready = !f_valid_ff || f_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         primed_ff  <= 1'b0;
         filt_ff    <= '0;
      end else begin
         if (accept) begin
            f_valid_ff <= 1'b1;
            primed_ff  <= 1'b1;
            filt_ff    <= filt_in;
         end else if (f_ready) begin
            f_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff <= raw;
         chg_ff <= req.charger_low;
      end
   end

   assign f_valid = f_valid_ff;
   assign f_raw   = raw_ff;
   assign f_chg   = chg_ff;
   assign f_filt  = filt_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bpsm_control.sv -----
// bpsm_control: debounced power-state machine, settling window and report logic
// depends on bpsm_pkg
`default_nettype none

module bpsm_control #(
   parameter int FRACTION_BITS = bpsm_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  bpsm_pkg::cfg_type                       cfg,
   input  wire logic                               f_valid,
   output logic                                    f_ready,
   input  wire logic [13:0]                        f_raw,
   input  wire logic                               f_chg,
   input  wire logic [13+FRACTION_BITS:0]          f_filt,
   output logic                                    s_valid,
   input  wire logic                               s_ready,
   output bpsm_pkg::info_type                      s_info,
   output logic [13+FRACTION_BITS:0]               s_filt
);

   localparam int FW = 14 + FRACTION_BITS;

   bpsm_pkg::mode_type   mode_ff, mode_in;
   bpsm_pkg::mode_type   last_ff, last_in;
   bpsm_pkg::mode_type   rmode_ff, rmode_in;
   logic signed [14:0]   rv_ff, rv_in;
   logic                 settling_ff, settling_in;
   logic [2:0]           stable_ff, stable_in;
   logic [FW-1:0]        ref_ff, ref_in;
   logic [3:0]           low_ff, low_in;
   logic [1:0]           run_ff, run_in;
   logic [1:0]           full_ff, full_in;
   logic [1:0]           chgc_ff, chgc_in;
   logic                 s_valid_ff;
   bpsm_pkg::info_type   s_info_ff;
   logic [FW-1:0]        s_filt_ff;

   logic [13:0]          vint;
   logic [FW-1:0]        thr_fx;
   logic [FW-1:0]        low_fx;
   logic [FW-1:0]        ref_diff;
   logic                 above_usb;
   logic                 usb;
   logic                 sleep;
   logic                 report;
   logic                 vch;
   logic                 sch;
   logic signed [15:0]   vdiff;
   logic [15:0]          vabs;
   logic                 advance;

   assign vint      = f_filt[FW-1:FRACTION_BITS];
   assign thr_fx    = FW'({cfg.change_threshold_mv, {FRACTION_BITS{1'b0}}});
   assign low_fx    = {cfg.low_threshold_mv, {FRACTION_BITS{1'b0}}};
   assign ref_diff  = (f_filt > ref_ff) ? (f_filt - ref_ff) : (ref_ff - f_filt);
   assign above_usb = f_raw > cfg.usb_threshold_mv;
   assign advance   = f_valid && f_ready;
   assign f_ready   = !s_valid_ff || s_ready;

   always_comb begin
      mode_in     = mode_ff;
      last_in     = last_ff;
      rmode_in    = rmode_ff;
      rv_in       = rv_ff;
      settling_in = settling_ff;
      stable_in   = stable_ff;
      ref_in      = ref_ff;
      low_in      = low_ff;
      run_in      = run_ff;
      full_in     = full_ff;
      chgc_in     = chgc_ff;
      sleep       = 1'b0;
      report      = 1'b0;
      vch         = 1'b0;
      sch         = 1'b0;
      vdiff       = '0;
      vabs        = '0;
      usb         = f_chg || (above_usb && (mode_ff != bpsm_pkg::MODE_RUN));

      // settling window: five quiet samples in a row close it
      if (settling_ff) begin
         if (ref_diff < thr_fx) begin
            stable_in = stable_ff + 3'd1;
            if (stable_in >= bpsm_pkg::SETTLE_COUNT) begin
               settling_in = 1'b0;
               rv_in = $signed({1'b0, vint}) - $signed({5'd0, cfg.change_threshold_mv})
                       - 15'sd1;
            end
         end else begin
            stable_in = '0;
         end
         ref_in = f_filt;
      end

      if (usb) begin
         low_in = '0;
         run_in = '0;
         if (f_chg) begin
            full_in = '0;
            if (mode_ff != bpsm_pkg::MODE_CHARGING) begin
               if (chgc_ff < bpsm_pkg::DEBOUNCE_MAX) chgc_in = chgc_ff + 2'd1;
               else mode_in = bpsm_pkg::MODE_CHARGING;
            end else begin
               chgc_in = bpsm_pkg::DEBOUNCE_MAX;
            end
         end else if (above_usb && (mode_ff == bpsm_pkg::MODE_CHARGING ||
                                    mode_ff == bpsm_pkg::MODE_FULL)) begin
            chgc_in = '0;
            if (mode_ff != bpsm_pkg::MODE_FULL) begin
               if (full_ff < bpsm_pkg::DEBOUNCE_MAX) full_in = full_ff + 2'd1;
               else mode_in = bpsm_pkg::MODE_FULL;
            end else begin
               full_in = bpsm_pkg::DEBOUNCE_MAX;
            end
         end else begin
            full_in = '0;
            chgc_in = '0;
            if (mode_ff == bpsm_pkg::MODE_INIT || mode_ff == bpsm_pkg::MODE_RUN ||
                mode_ff == bpsm_pkg::MODE_LOW) begin
               mode_in = bpsm_pkg::MODE_USB;
            end
         end
      end else begin
         full_in = '0;
         chgc_in = '0;
         if (mode_ff == bpsm_pkg::MODE_FULL || mode_ff == bpsm_pkg::MODE_USB ||
             mode_ff == bpsm_pkg::MODE_INIT) begin
            mode_in = bpsm_pkg::MODE_RUN;
            run_in  = '0;
            low_in  = '0;
         end else if (f_filt < low_fx) begin
            mode_in = bpsm_pkg::MODE_LOW;
            if (low_ff < bpsm_pkg::LOW_LIMIT) begin
               low_in = low_ff + 4'd1;
            end else begin
               run_in = '0;
               sleep  = 1'b1;
            end
         end else begin
            low_in = '0;
            if (run_ff < bpsm_pkg::DEBOUNCE_MAX) run_in = run_ff + 2'd1;
            else mode_in = bpsm_pkg::MODE_RUN;
         end
      end

      // any state change opens a new settling window
      if (mode_in != last_ff) begin
         last_in     = mode_in;
         settling_in = 1'b1;
         stable_in   = '0;
         ref_in      = f_filt;
      end

      if (!settling_in) begin
         vdiff = $signed({2'd0, vint}) - $signed({rv_in[14], rv_in});
         vabs  = vdiff[15] ? 16'(-vdiff) : 16'(vdiff);
         vch   = vabs >= {6'd0, cfg.change_threshold_mv};
         sch   = mode_in != rmode_ff;
         if (vch) rv_in = {1'b0, vint};
         if (sch) rmode_in = mode_in;
         report = vch || sch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= bpsm_pkg::MODE_INIT;
         last_ff     <= bpsm_pkg::MODE_INIT;
         rmode_ff    <= bpsm_pkg::MODE_INIT;
         rv_ff       <= '0;
         settling_ff <= 1'b0;
         stable_ff   <= '0;
         ref_ff      <= '0;
         low_ff      <= '0;
         run_ff      <= '0;
         full_ff     <= '0;
         chgc_ff     <= '0;
         s_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff     <= mode_in;
            last_ff     <= last_in;
            rmode_ff    <= rmode_in;
            rv_ff       <= rv_in;
            settling_ff <= settling_in;
            stable_ff   <= stable_in;
            ref_ff      <= ref_in;
            low_ff      <= low_in;
            run_ff      <= run_in;
            full_ff     <= full_in;
            chgc_ff     <= chgc_in;
            s_valid_ff  <= 1'b1;
         end else if (s_ready) begin
            s_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_info_ff.voltage_mv     <= (vint > bpsm_pkg::VOLTAGE_MAX) ? bpsm_pkg::VOLTAGE_MAX
                                                                    : vint;
         s_info_ff.mode           <= mode_in;
         s_info_ff.usb_powered    <= usb;
         s_info_ff.report_changed <= report;
         s_info_ff.sleep_request  <= sleep;
         s_info_ff.pct_update     <= !settling_in;
         s_filt_ff                <= f_filt;
      end
   end

   assign s_valid = s_valid_ff;
   assign s_info  = s_info_ff;
   assign s_filt  = s_filt_ff;

`ifndef SYNTH
   a_sleep_only_low: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && s_info_ff.sleep_request |-> s_info_ff.mode == bpsm_pkg::MODE_LOW)
      else $error("sleep request outside low state");

   a_no_report_settling: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && !s_info_ff.pct_update |-> !s_info_ff.report_changed)
      else $error("report raised inside settling window");

   a_stable_bound: assert property (@(posedge clock) disable iff (reset)
      settling_ff |-> stable_ff < bpsm_pkg::SETTLE_COUNT)
      else $error("settling window missed its close");

   a_low_bound: assert property (@(posedge clock) disable iff (reset)
      low_ff <= bpsm_pkg::LOW_LIMIT)
      else $error("low counter overran its limit");

   a_mode_change_settles: assert property (@(posedge clock) disable iff (reset)
      advance && (mode_in != last_ff) |=> settling_ff && (stable_ff == 3'd0))
      else $error("state change did not open settling window");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/bpsm_percent.sv -----
// bpsm_percent: output stage, charge percentage from the filtered voltage
// and the result register; depends on bpsm_pkg and bpsm_rsp_if
`default_nettype none

module bpsm_percent #(
   parameter int FRACTION_BITS = bpsm_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               s_valid,
   output logic                                    s_ready,
   input  bpsm_pkg::info_type                      s_info,
   input  wire logic [13+FRACTION_BITS:0]          s_filt,
   bpsm_rsp_if.source                              rsp
);

   localparam int FW = 14 + FRACTION_BITS;
   localparam logic [13:0] KNEE_4000 = 14'd4000;
   localparam logic [13:0] KNEE_3800 = 14'd3800;
   localparam logic [13:0] KNEE_3650 = 14'd3650;
   localparam logic [13:0] KNEE_3500 = 14'd3500;
   localparam logic [13:0] KNEE_3300 = 14'd3300;

   logic                 o_valid_ff;
   logic [6:0]           held_ff;
   logic [13:0]          voltage_ff;
   logic [2:0]           state_ff;
   logic                 usb_ff;
   logic                 report_ff;
   logic                 sleep_ff;
   logic                 advance;

   logic [13:0]          vint;
   logic [13:0]          d3800, d3500, d3300;
   logic [FW-1:0]        d3650;
   logic [FW-1:0]        k3650;
   logic [9:0]           n15;
   logic [15:0]          p10, p5, p20;
   logic [22:0]          p15;
   logic [6:0]           curve;
   logic [6:0]           pct;

   assign vint  = s_filt[FW-1:FRACTION_BITS];
   assign k3650 = {KNEE_3650, {FRACTION_BITS{1'b0}}};
   assign d3800 = vint - KNEE_3800;
   assign d3500 = vint - KNEE_3500;
   assign d3300 = vint - KNEE_3300;
   // four times the excess, in whole millivolts
   assign d3650 = (s_filt - k3650) >> (FRACTION_BITS - 2);
   assign n15   = d3650[9:0];

   // small constant divides as reciprocal multiplies, exact over their ranges
   assign p10 = {8'd0, d3800[7:0]} * 16'd205;
   assign p5  = {8'd0, d3500[7:0]} * 16'd205;
   assign p20 = {8'd0, d3300[7:0]} * 16'd205;
   assign p15 = {13'd0, n15} * 23'd4370;

   always_comb begin
      if (vint >= KNEE_4000)      curve = bpsm_pkg::PCT_FULL;
      else if (vint >= KNEE_3800) curve = 7'd80 + 7'(p10 >> 11);
      else if (vint >= KNEE_3650) curve = 7'd40 + 7'(p15 >> 16);
      else if (vint >= KNEE_3500) curve = 7'd10 + 7'(p5 >> 10);
      else if (vint >= KNEE_3300) curve = 7'(p20 >> 12);
      else                        curve = 7'd0;
   end

   always_comb begin
      case (s_info.mode)
         bpsm_pkg::MODE_CHARGING: pct = bpsm_pkg::PCT_CHARGING;
         bpsm_pkg::MODE_USB:      pct = bpsm_pkg::PCT_USB;
         bpsm_pkg::MODE_FULL:     pct = bpsm_pkg::PCT_FULL;
         default:                 pct = curve;
      endcase
   end

   assign advance = s_valid && s_ready;
   assign s_ready = !o_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         if (advance) begin
            o_valid_ff <= 1'b1;
            if (s_info.pct_update) held_ff <= pct;
         end else if (rsp.ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         voltage_ff <= s_info.voltage_mv;
         state_ff   <= s_info.mode;
         usb_ff     <= s_info.usb_powered;
         report_ff  <= s_info.report_changed;
         sleep_ff   <= s_info.sleep_request;
      end
   end

   assign rsp.valid          = o_valid_ff;
   assign rsp.voltage_mv     = voltage_ff;
   assign rsp.percentage     = held_ff;
   assign rsp.power_state    = state_ff;
   assign rsp.usb_powered    = usb_ff;
   assign rsp.report_changed = report_ff;
   assign rsp.sleep_request  = sleep_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/battery_power_state_monitor.sv -----
// battery_power_state_monitor: top level of the battery power-state monitor
// depends on bpsm_pkg, bpsm_req_if, bpsm_rsp_if, bpsm_csr, bpsm_filter,
// bpsm_control and bpsm_percent
`default_nettype none

// Takes one converter reading per item and returns one result per item, in
// order. The block is a three-stage pipeline: the input stage corrects the
// reading and updates the voltage filter as the item is accepted, the control
// stage runs the debounced power-state machine, settling window and report
// logic, and the output stage works out the charge percentage and holds the
// result. An item may be accepted in every cycle while the result side does
// not stall, and its result is registered by the input, control and output
// stages in turn; a stalled result backs up through the stages, so up to three
// items are in flight. Configuration registers sit on an APB-style port
// (pready always high) and are to be written only while the block is idle.

module battery_power_state_monitor #(
   parameter int FRACTION_BITS = bpsm_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bpsm_req_if.sink                                  req_chan,
   bpsm_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bpsm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [bpsm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [bpsm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   localparam int FW = 14 + FRACTION_BITS;

   bpsm_pkg::cfg_type    cfg;
   logic                 f_valid;
   logic                 f_ready;
   logic [13:0]          f_raw;
   logic                 f_chg;
   logic [FW-1:0]        f_filt;
   logic                 s_valid;
   logic                 s_ready;
   bpsm_pkg::info_type   s_info;
   logic [FW-1:0]        s_filt;

   bpsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bpsm_filter #(.FRACTION_BITS(FRACTION_BITS)) u_filter (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_chan),
      .f_valid (f_valid),
      .f_ready (f_ready),
      .f_raw   (f_raw),
      .f_chg   (f_chg),
      .f_filt  (f_filt)
   );

   bpsm_control #(.FRACTION_BITS(FRACTION_BITS)) u_control (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .f_valid (f_valid),
      .f_ready (f_ready),
      .f_raw   (f_raw),
      .f_chg   (f_chg),
      .f_filt  (f_filt),
      .s_valid (s_valid),
      .s_ready (s_ready),
      .s_info  (s_info),
      .s_filt  (s_filt)
   );

   bpsm_percent #(.FRACTION_BITS(FRACTION_BITS)) u_percent (
      .clock   (clock),
      .reset   (reset),
      .s_valid (s_valid),
      .s_ready (s_ready),
      .s_info  (s_info),
      .s_filt  (s_filt),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench of the battery power-state monitor
// drives readings and register writes, predicts every result and checks it
// depends on bpsm_pkg, bpsm_req_if, bpsm_rsp_if and battery_power_state_monitor

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpsm_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEFAULT;
   localparam longint unsigned ONE_FX = 64'd1 << FRAC;
   localparam int CLOCK_PERIOD = 12;
   localparam int TIMEOUT_CYCLES = 200_000;

   typedef struct packed {
      logic [13:0] voltage_mv;
      logic [6:0]  percentage;
      mode_type    power_state;
      logic        usb_powered;
      logic        report_changed;
      logic        sleep_request;
   } reading_result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   bpsm_req_if req_bus ();
   bpsm_rsp_if rsp_bus ();

   battery_power_state_monitor #(.FRACTION_BITS(FRAC)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // register copy used by the predictor
   logic [13:0] cfg_usb    = USB_THRESHOLD_RESET;
   logic [13:0] cfg_low    = LOW_THRESHOLD_RESET;
   logic [13:0] cfg_step   = STEP_THRESHOLD_RESET;
   logic [8:0]  cfg_weight = SMOOTHING_WEIGHT_RESET;
   logic [9:0]  cfg_change = CHANGE_THRESHOLD_RESET;

   // monitor state as the predictor sees it
   int unsigned filt_fx    = 0;
   bit          primed     = 1'b0;
   mode_type    mode_now   = MODE_INIT;
   mode_type    last_mode  = MODE_INIT;
   mode_type    shown_mode = MODE_INIT;
   int          shown_volt = 0;
   bit          settling   = 1'b0;
   int unsigned stable_n   = 0;
   int unsigned settle_ref = 0;
   int unsigned low_n = 0, run_n = 0, full_n = 0, charge_n = 0;
   logic [6:0]  held_pct   = 7'd0;

   reading_result_type pending_results[$];
   reading_result_type wanted_result;

   int   errors = 0;
   int   items_sent = 0;
   int   results_checked = 0;
   int   reports_seen = 0;
   int   sleeps_seen = 0;
   int   settings_applied = 0;
   logic [7:0] modes_seen = 8'd0;
   bit   steady_flow = 1'b0;

   function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // advances the monitor state by one reading and returns the result it gives
   function automatic reading_result_type predict_result(input logic [11:0] adc,
                                                         input logic chg);
      int unsigned raw, raw_fx, weight, change_fx, vint;
      longint unsigned mix, fx;
      int gap;
      logic usb, sleep_req, report, volt_moved, mode_moved;
      reading_result_type r;

      raw = 32'(adc) * 2 + 32'(ADC_OFFSET_MV);
      raw_fx = raw << FRAC;
      weight = (cfg_weight > WEIGHT_FULL) ? 32'(WEIGHT_FULL) : 32'(cfg_weight);
      change_fx = 32'(cfg_change) << FRAC;
      sleep_req = 1'b0;
      report = 1'b0;

      if (!primed) begin
         filt_fx = raw_fx;
         primed = 1'b1;
      end

      usb = chg || (raw > 32'(cfg_usb) && mode_now != MODE_RUN);

      if (abs_gap(raw_fx, filt_fx) > (32'(cfg_step) << FRAC)) begin
         filt_fx = raw_fx;
      end else begin
         mix = 64'(weight) * 64'(raw_fx) + 64'(256 - weight) * 64'(filt_fx);
         filt_fx = 32'(mix >> 8);
      end
      vint = filt_fx >> FRAC;

      if (settling) begin
         if (abs_gap(filt_fx, settle_ref) < change_fx) begin
            stable_n++;
            if (stable_n >= SETTLE_COUNT) begin
               settling = 1'b0;
               // pushes the last reported voltage out of range so a report follows
               shown_volt = int'(vint) - int'(cfg_change) - 1;
            end
         end else begin
            stable_n = 0;
         end
         settle_ref = filt_fx;
      end

      if (usb) begin
         low_n = 0;
         run_n = 0;
         if (chg) begin
            full_n = 0;
            if (mode_now != MODE_CHARGING) begin
               if (charge_n < DEBOUNCE_MAX) charge_n++;
               else mode_now = MODE_CHARGING;
            end else begin
               charge_n = DEBOUNCE_MAX;
            end
         end else if (raw > 32'(cfg_usb)
                      && (mode_now == MODE_CHARGING || mode_now == MODE_FULL)) begin
            charge_n = 0;
            if (mode_now != MODE_FULL) begin
               if (full_n < DEBOUNCE_MAX) full_n++;
               else mode_now = MODE_FULL;
            end else begin
               full_n = DEBOUNCE_MAX;
            end
         end else begin
            full_n = 0;
            charge_n = 0;
            if (mode_now == MODE_INIT || mode_now == MODE_RUN || mode_now == MODE_LOW)
               mode_now = MODE_USB;
         end
      end else begin
         full_n = 0;
         charge_n = 0;
         if (mode_now == MODE_FULL || mode_now == MODE_USB || mode_now == MODE_INIT) begin
            mode_now = MODE_RUN;
            run_n = 0;
            low_n = 0;
         end else if (filt_fx < (32'(cfg_low) << FRAC)) begin
            mode_now = MODE_LOW;
            if (low_n < LOW_LIMIT) begin
               low_n++;
            end else begin
               run_n = 0;
               sleep_req = 1'b1;
            end
         end else begin
            low_n = 0;
            if (run_n < DEBOUNCE_MAX) run_n++;
            else mode_now = MODE_RUN;
         end
      end

      if (mode_now != last_mode) begin
         last_mode = mode_now;
         settling = 1'b1;
         stable_n = 0;
         settle_ref = filt_fx;
      end

      if (!settling) begin
         fx = filt_fx;
         if (mode_now == MODE_CHARGING) held_pct = PCT_CHARGING;
         else if (mode_now == MODE_USB) held_pct = PCT_USB;
         else if (mode_now == MODE_FULL) held_pct = PCT_FULL;
         else if (fx >= 4000 * ONE_FX) held_pct = PCT_FULL;
         else if (fx >= 3800 * ONE_FX)
            held_pct = 7'(80 + (fx - 3800 * ONE_FX) / (10 * ONE_FX));
         else if (fx >= 3650 * ONE_FX)
            held_pct = 7'(40 + ((fx - 3650 * ONE_FX) * 4) / (15 * ONE_FX));
         else if (fx >= 3500 * ONE_FX)
            held_pct = 7'(10 + (fx - 3500 * ONE_FX) / (5 * ONE_FX));
         else if (fx >= 3300 * ONE_FX)
            held_pct = 7'((fx - 3300 * ONE_FX) / (20 * ONE_FX));
         else held_pct = 7'd0;

         gap = int'(vint) - shown_volt;
         if (gap < 0) gap = -gap;
         volt_moved = gap >= int'(cfg_change);
         mode_moved = mode_now != shown_mode;
         if (volt_moved) shown_volt = int'(vint);
         if (mode_moved) shown_mode = mode_now;
         report = volt_moved || mode_moved;
      end

      r.voltage_mv     = (vint > 32'(VOLTAGE_MAX)) ? VOLTAGE_MAX : 14'(vint);
      r.percentage     = held_pct;
      r.power_state    = mode_now;
      r.usb_powered    = usb;
      r.report_changed = report;
      r.sleep_request  = sleep_req;
      return r;
   endfunction

   function automatic logic [11:0] to_adc(input int raw);
      int code;
      code = (raw - int'(ADC_OFFSET_MV)) / 2;
      if (code < 0) code = 0;
      if (code > 4095) code = 4095;
      return 12'(code);
   endfunction

   function automatic int jittered(input int level, input int spread);
      return level + int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // sends one item, with random idle cycles ahead of it unless steady_flow is set, and records its result
   task automatic send_reading(input logic [11:0] adc, input logic chg);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 35) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid          <= 1'b1;
      req_bus.adc_millivolts <= adc;
      req_bus.charger_low    <= chg;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_result(adc, chg));
      items_sent++;
   endtask

   task automatic drain_results(input int settle_cycles);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
   endtask

   // write through the csr port, then read the register back
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] stored;
      case (index)
         REG_USB_THRESHOLD: begin
            cfg_usb = value[13:0];
            stored = 32'(value[13:0]);
         end
         REG_LOW_THRESHOLD: begin
            cfg_low = value[13:0];
            stored = 32'(value[13:0]);
         end
         REG_STEP_THRESHOLD: begin
            cfg_step = value[13:0];
            stored = 32'(value[13:0]);
         end
         REG_SMOOTHING_WEIGHT: begin
            cfg_weight = value[8:0];
            stored = 32'(value[8:0]);
         end
         REG_CHANGE_THRESHOLD: begin
            cfg_change = value[9:0];
            stored = 32'(value[9:0]);
         end
         default: stored = 32'd0;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // back-to-back read of the same register
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         errors++;
         $error("register %0d readback: expected %0d, got %0d", index, stored, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input int usb, input int low, input int step,
                                 input int weight, input int change);
      write_register(REG_USB_THRESHOLD, usb);
      write_register(REG_LOW_THRESHOLD, low);
      write_register(REG_STEP_THRESHOLD, step);
      write_register(REG_SMOOTHING_WEIGHT, weight);
      write_register(REG_CHANGE_THRESHOLD, change);
      settings_applied++;
   endtask

   // mostly well-formed power episodes with random content, some noise
   task automatic drive_traffic(input int count);
      int stop_at, pick, len, level, other, lo, hi;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         len = $urandom_range(4, 24);
         if (pick < 25) begin
            // battery resting at one level
            level = $urandom_range(2900, 4400);
            repeat (len) send_reading(to_adc(jittered(level, 8)), 1'b0);
         end else if (pick < 40) begin
            // under the low threshold long enough to reach the sleep request
            hi = (cfg_low > 66) ? int'(cfg_low) - 1 : 65;
            lo = (hi > 665) ? hi - 600 : 65;
            level = $urandom_range(lo, hi);
            repeat (len + 8) send_reading(to_adc(jittered(level, 5)), 1'b0);
         end else if (pick < 50) begin
            lo = int'(cfg_usb) + 1;
            if (lo > 8255) lo = 8255;
            level = $urandom_range(lo, 8255);
            repeat (len / 2 + 2) send_reading(to_adc(jittered(level, 5)), 1'b0);
         end else if (pick < 62) begin
            level = $urandom_range(3500, 4300);
            repeat (len / 2 + 2) send_reading(to_adc(jittered(level, 5)), 1'b1);
         end else if (pick < 74) begin
            // charge, then stay on a high supply until reported full
            level = $urandom_range(3800, 4200);
            repeat ($urandom_range(4, 7)) send_reading(to_adc(jittered(level, 5)), 1'b1);
            lo = int'(cfg_usb) + 1;
            if (lo > 8255) lo = 8255;
            level = $urandom_range(lo, 8255);
            repeat ($urandom_range(4, 10)) send_reading(to_adc(level), 1'b0);
         end else if (pick < 84) begin
            level = $urandom_range(65, 8255);
            other = $urandom_range(65, 8255);
            for (int i = 0; i < len; i++)
               send_reading(to_adc((i % 2 == 0) ? level : other), 1'b0);
         end else begin
            repeat ($urandom_range(1, 8))
               send_reading($urandom_range(0, 4095), $urandom_range(0, 1));
         end
      end
   endtask

   task automatic run_phase(input int usb, input int low, input int step, input int weight,
                            input int change, input int count);
      drain_results(4);
      apply_settings(usb, low, step, weight, change);
      drive_traffic(count);
   endtask

   task automatic test_priming();
      send_reading(12'd1800, 1'b0);
      send_reading(12'd1810, 1'b0);
   endtask

   task automatic test_field_extremes();
      send_reading(12'd0, 1'b0);
      send_reading(12'd4095, 1'b0);
      send_reading(12'hAAA, 1'b0);
      send_reading(12'h555, 1'b1);
      send_reading(12'd4095, 1'b1);
   endtask

   // charger on until charging, high supply until full, then back on battery
   task automatic test_charge_cycle();
      repeat (5) send_reading(12'd2000, 1'b1);
      repeat (5) send_reading(12'd2300, 1'b0);
      repeat (3) send_reading(12'd1900, 1'b0);
   endtask

   task automatic test_nominal_settings();
      run_phase(4400, 3400, 150, 40, 15, 300);
   endtask

   task automatic test_filter_extremes();
      run_phase(4500, 3300, 200, 0, 20, 120);
      run_phase(4500, 3300, 200, 256, 20, 120);
      run_phase(4500, 3300, 0, 511, 20, 120);
      run_phase(4500, 3300, 16383, 26, 20, 120);
   endtask

   task automatic test_change_threshold_extremes();
      run_phase(4500, 3300, 200, 26, 0, 120);
      run_phase(4500, 3300, 200, 26, 1, 120);
      run_phase(4500, 3300, 200, 26, 1023, 120);
   endtask

   task automatic test_detection_extremes();
      run_phase(0, 3300, 200, 26, 20, 100);
      run_phase(16383, 3300, 200, 26, 20, 100);
      run_phase(4500, 0, 200, 26, 20, 100);
      run_phase(4500, 16383, 200, 26, 20, 100);
   endtask

   task automatic test_random_settings();
      repeat (3)
         run_phase($urandom_range(3000, 8255), $urandom_range(2800, 4000),
                   $urandom_range(0, 1000), $urandom_range(0, 511),
                   $urandom_range(0, 1023), 120);
   endtask

   task automatic test_no_idle();
      drain_results(4);
      steady_flow <= 1'b1;
      apply_settings(4500, 3300, $urandom_range(50, 400), $urandom_range(10, 80),
                     $urandom_range(5, 40));
      drive_traffic(250);
      drain_results(4);
      steady_flow <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // result side: random stalls unless steady_flow is set, and every item compared with the oldest prediction
   always @(posedge clock) begin
      rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 35);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $error("result item arrived with no prediction pending");
         end else begin
            wanted_result = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.report_changed === 1'b1) reports_seen++;
            if (rsp_bus.sleep_request === 1'b1) sleeps_seen++;
            modes_seen[rsp_bus.power_state] = 1'b1;
            if (rsp_bus.voltage_mv !== wanted_result.voltage_mv) begin
               errors++;
               $error("voltage_mv: expected %0d, got %0d",
                      wanted_result.voltage_mv, rsp_bus.voltage_mv);
            end
            if (rsp_bus.percentage !== wanted_result.percentage) begin
               errors++;
               $error("percentage: expected %0d, got %0d",
                      wanted_result.percentage, rsp_bus.percentage);
            end
            if (rsp_bus.power_state !== wanted_result.power_state) begin
               errors++;
               $error("power_state: expected %0d, got %0d",
                      wanted_result.power_state, rsp_bus.power_state);
            end
            if (rsp_bus.usb_powered !== wanted_result.usb_powered) begin
               errors++;
               $error("usb_powered: expected %0d, got %0d",
                      wanted_result.usb_powered, rsp_bus.usb_powered);
            end
            if (rsp_bus.report_changed !== wanted_result.report_changed) begin
               errors++;
               $error("report_changed: expected %0d, got %0d",
                      wanted_result.report_changed, rsp_bus.report_changed);
            end
            if (rsp_bus.sleep_request !== wanted_result.sleep_request) begin
               errors++;
               $error("sleep_request: expected %0d, got %0d",
                      wanted_result.sleep_request, rsp_bus.sleep_request);
            end
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.adc_millivolts = 12'd0;
      req_bus.charger_low    = 1'b0;
      rsp_bus.ready          = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_priming();
      test_field_extremes();
      test_charge_cycle();
      test_nominal_settings();
      test_filter_extremes();
      test_change_threshold_extremes();
      test_detection_extremes();
      test_random_settings();
      test_no_idle();
      drain_results(10);

      $display("covered %0d items over %0d register settings; states seen %b",
               results_checked, settings_applied, modes_seen[5:0]);
      $display("saw %0d change reports and %0d sleep requests", reports_seen, sleeps_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d results still pending", pending_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bpsm_pkg.sv
hw/rtl/bpsm_req_if.sv
hw/rtl/bpsm_rsp_if.sv
hw/rtl/bpsm_csr.sv
hw/rtl/bpsm_filter.sv
hw/rtl/bpsm_control.sv
hw/rtl/bpsm_percent.sv
hw/rtl/battery_power_state_monitor.sv
tb/tb_top.sv
